[rtl/core/occupancy_grid_affine_merge_assert.svh]
// Assertion macros for the occupancy grid merge block.
// Included by the RTL files that carry assertions; expects clk and rst in scope.
`ifndef OCCUPANCY_GRID_AFFINE_MERGE_ASSERT_SVH
`define OCCUPANCY_GRID_AFFINE_MERGE_ASSERT_SVH

// Checked only outside reset.
`define OGAM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define OGAM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/ogam_pkg.sv]
// Shared types and constants of the occupancy grid merge block.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none

package ogam_pkg;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int COEF_W     = 32;
  localparam int SIZE_W     = 10;
  localparam int SRC_W      = 10;
  localparam int CELL_W     = 8;
  localparam int GIDX_W     = 18;

  localparam logic signed [CELL_W-1:0] UNKNOWN_CELL = -8'sd1;

  typedef enum logic [1:0] {
    OP_MERGE = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_FROM_COL    = 3'd0,
    CFG_X_FROM_ROW    = 3'd1,
    CFG_X_OFFSET      = 3'd2,
    CFG_Y_FROM_COL    = 3'd3,
    CFG_Y_FROM_ROW    = 3'd4,
    CFG_Y_OFFSET      = 3'd5,
    CFG_MERGED_WIDTH  = 3'd6,
    CFG_MERGED_HEIGHT = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_SUM,
    S_CHK,
    S_ADDR,
    S_READ,
    S_WB,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]               op;
    logic [SRC_W-1:0]         src_col;
    logic [SRC_W-1:0]         src_row;
    logic signed [CELL_W-1:0] cell_value;
    logic [GIDX_W-1:0]        grid_index;
  } in_item_t;

  typedef struct packed {
    logic                     in_bounds;
    logic [GIDX_W-1:0]        target_index;
    logic                     updated;
    logic signed [CELL_W-1:0] read_value;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/core/ogam_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ogam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 262144
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/occupancy_grid_affine_merge.sv]
// Occupancy grid merge: affine cell mapping and max-priority store into the grid RAM.
// Depends on ogam_pkg, ogam_ram and occupancy_grid_affine_merge_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "occupancy_grid_affine_merge_assert.svh"

// Merges source occupancy cells into a GRID_DIM_MAX x GRID_DIM_MAX grid held in one
// RAM, keeping the larger value per cell, and serves reads and clears of that grid.
// Each merge maps (src_col, src_row) through a Q.FRAC_BITS affine transform, rounds
// half away from zero and checks the result against merged_width/merged_height.
// One item is in flight at a time; it runs through multiply, sum and bounds check
// steps, and an item that reaches the grid then goes through address, RAM read and
// write-back steps, a single read-modify-write pass over the grid RAM; one that falls
// outside it skips them. After reset the block sweeps the RAM to unknown (-1), one
// cell per cycle, over all GRID_DIM_MAX*GRID_DIM_MAX cells (262144 at the default),
// with in_stall high; configuration writes are taken during the sweep. Write
// configuration only while no item is in flight. A result waits in an output
// register until taken.
module occupancy_grid_affine_merge
  import ogam_pkg::*;
#(
  parameter int GRID_DIM_MAX = 512,
  parameter int SRC_DIM_MAX  = 1024,
  parameter int FRAC_BITS    = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH   = GRID_DIM_MAX * GRID_DIM_MAX;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int DIM_W   = $clog2(GRID_DIM_MAX + 1);
  localparam int EXT_W   = (DIM_W > SIZE_W) ? DIM_W : SIZE_W;
  localparam int MULT_W  = COEF_W + SRC_W + 1;
  localparam int ACC_W   = MULT_W + 2;
  localparam int HI_W    = ACC_W - FRAC_BITS;
  localparam int AREA_W  = 2 * DIM_W;
  localparam int GEXT_W  = (AREA_W > GIDX_W) ? AREA_W : GIDX_W;
  localparam int IEXT_W  = (ADDR_W > GIDX_W) ? ADDR_W : GIDX_W;
  localparam logic signed [ACC_W-1:0] HALF = {{(ACC_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

  // configuration
  logic signed [COEF_W-1:0] x_from_col, x_from_row, x_offset;
  logic signed [COEF_W-1:0] y_from_col, y_from_row, y_offset;
  logic [SIZE_W-1:0]        merged_width, merged_height;

  // derived sizes
  logic [DIM_W-1:0]  w_eff, h_eff;
  logic [AREA_W-1:0] area;

  state_t state, state_next;

  in_item_t                 item;
  logic signed [MULT_W-1:0] prod_xc, prod_xr, prod_yc, prod_yr;
  logic signed [ACC_W-1:0]  acc_x, acc_y;
  logic [DIM_W-1:0]         mx, my;
  logic [ADDR_W-1:0]        addr;
  logic [ADDR_W-1:0]        clr_addr;
  out_item_t                res;

  logic                     ram_re, ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [CELL_W-1:0]        ram_wdata, ram_rdata;
  logic                     out_load;

  // combinational datapath
  logic signed [SRC_W:0]    col_s, row_s;
  logic [HI_W-1:0]          hi_x, hi_y;
  logic                     x_ok, y_ok, src_ok, gidx_ok, chk_inb;
  logic [AREA_W-1:0]        pidx;
  logic [IEXT_W-1:0]        gext, tgt_ext;
  logic signed [CELL_W-1:0] rd_val, wb_val, new_val;
  logic                     wb_upd;

  // ---------------------------------------------------------------------------
  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_from_col    <= 32'sd65536;
      x_from_row    <= '0;
      x_offset      <= '0;
      y_from_col    <= '0;
      y_from_row    <= 32'sd65536;
      y_offset      <= '0;
      merged_width  <= SIZE_W'(512);
      merged_height <= SIZE_W'(512);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_X_FROM_COL:    x_from_col    <= cfg_data;
        CFG_X_FROM_ROW:    x_from_row    <= cfg_data;
        CFG_X_OFFSET:      x_offset      <= cfg_data;
        CFG_Y_FROM_COL:    y_from_col    <= cfg_data;
        CFG_Y_FROM_ROW:    y_from_row    <= cfg_data;
        CFG_Y_OFFSET:      y_offset      <= cfg_data;
        CFG_MERGED_WIDTH:  merged_width  <= cfg_data[SIZE_W-1:0];
        CFG_MERGED_HEIGHT: merged_height <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate sizes to the grid and keep the cell count ready for read/clear checks.
  always_ff @(posedge clk) begin
    if (EXT_W'(merged_width) > EXT_W'(GRID_DIM_MAX)) begin
      w_eff <= DIM_W'(GRID_DIM_MAX);
    end else begin
      w_eff <= DIM_W'(merged_width);
    end
    if (EXT_W'(merged_height) > EXT_W'(GRID_DIM_MAX)) begin
      h_eff <= DIM_W'(GRID_DIM_MAX);
    end else begin
      h_eff <= DIM_W'(merged_height);
    end
    area <= AREA_W'(w_eff) * AREA_W'(h_eff);
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_addr == ADDR_W'(DEPTH - 1)) state_next = S_IDLE;
      S_IDLE:  if (in_valid) state_next = S_MUL;
      S_MUL:   state_next = S_SUM;
      S_SUM:   state_next = S_CHK;
      S_CHK:   state_next = chk_inb ? S_ADDR : S_OUT;
      S_ADDR:  state_next = S_READ;
      S_READ:  state_next = S_WB;
      S_WB:    state_next = S_OUT;
      S_OUT:   if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    ram_re   = 1'b0;
    out_load = 1'b0;
    unique case (state)
      S_IDLE:  in_stall = 1'b0;
      S_READ:  ram_re   = 1'b1;
      S_OUT:   out_load = !out_valid || !out_stall;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath
  assign col_s = $signed({1'b0, item.src_col});
  assign row_s = $signed({1'b0, item.src_row});

  // A rounded coordinate is >= 0 exactly when acc + half > 0.
  assign hi_x = acc_x[ACC_W-1:FRAC_BITS];
  assign hi_y = acc_y[ACC_W-1:FRAC_BITS];
  assign x_ok = !acc_x[ACC_W-1] && (acc_x != '0) && (hi_x < HI_W'(w_eff));
  assign y_ok = !acc_y[ACC_W-1] && (acc_y != '0) && (hi_y < HI_W'(h_eff));
  assign src_ok = (32'(item.src_col) < 32'(SRC_DIM_MAX)) &&
                  (32'(item.src_row) < 32'(SRC_DIM_MAX));
  assign gidx_ok = GEXT_W'(item.grid_index) < GEXT_W'(area);

  always_comb begin
    unique case (item.op)
      OP_MERGE: chk_inb = src_ok && x_ok && y_ok;
      OP_READ,
      OP_CLEAR: chk_inb = gidx_ok;
      default:  chk_inb = 1'b0;
    endcase
  end

  assign pidx    = AREA_W'(my) * AREA_W'(w_eff) + AREA_W'(mx);
  assign gext    = IEXT_W'(item.grid_index);
  assign tgt_ext = IEXT_W'(addr);

  // Write-back decision on the cell just read.
  assign rd_val = $signed(ram_rdata);
  always_comb begin
    wb_upd = 1'b0;
    wb_val = UNKNOWN_CELL;
    unique case (item.op)
      OP_MERGE: begin
        wb_val = item.cell_value;
        wb_upd = !item.cell_value[CELL_W-1] && (item.cell_value > rd_val);
      end
      OP_CLEAR: begin
        wb_val = UNKNOWN_CELL;
        wb_upd = 1'b1;
      end
      default: ;
    endcase
  end
  assign new_val = wb_upd ? wb_val : rd_val;

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) item <= in_data;
      end
      S_MUL: begin
        prod_xc <= MULT_W'(x_from_col) * MULT_W'(col_s);
        prod_xr <= MULT_W'(x_from_row) * MULT_W'(row_s);
        prod_yc <= MULT_W'(y_from_col) * MULT_W'(col_s);
        prod_yr <= MULT_W'(y_from_row) * MULT_W'(row_s);
      end
      S_SUM: begin
        acc_x <= ACC_W'(prod_xc) + ACC_W'(prod_xr) + ACC_W'(x_offset) + HALF;
        acc_y <= ACC_W'(prod_yc) + ACC_W'(prod_yr) + ACC_W'(y_offset) + HALF;
      end
      S_CHK: begin
        mx <= hi_x[DIM_W-1:0];
        my <= hi_y[DIM_W-1:0];
        if (!chk_inb) begin
          res.in_bounds    <= 1'b0;
          res.target_index <= '0;
          res.updated      <= 1'b0;
          res.read_value   <= UNKNOWN_CELL;
        end
      end
      S_ADDR: begin
        if (item.op == OP_MERGE) begin
          addr <= pidx[ADDR_W-1:0];
        end else begin
          addr <= gext[ADDR_W-1:0];
        end
      end
      S_WB: begin
        res.in_bounds    <= 1'b1;
        res.target_index <= tgt_ext[GIDX_W-1:0];
        res.updated      <= wb_upd;
        res.read_value   <= new_val;
      end
      default: ;
    endcase
  end

  // Clearing sweep address.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == S_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign ram_we    = (state == S_CLEAR) || ((state == S_WB) && wb_upd);
  assign ram_waddr = (state == S_CLEAR) ? clr_addr : addr;
  assign ram_wdata = (state == S_CLEAR) ? UNKNOWN_CELL : wb_val;

  ogam_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  // Output register: hold the beat until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= res;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  `OGAM_ASSERT_ALWAYS(a_reset_sweep, rst |=> (state == S_CLEAR && !out_valid), "reset must start the clearing sweep")
  `OGAM_ASSERT(a_ram_write_state, ram_we |-> (state == S_CLEAR || state == S_WB), "grid written outside sweep or write-back")
  `OGAM_ASSERT(a_merge_grows, (ram_we && state == S_WB && item.op == OP_MERGE) |-> ($signed(ram_wdata) > $signed(ram_rdata)), "merge write does not raise the cell")
  `OGAM_ASSERT(a_oob_result, (out_valid && !out_data.in_bounds) |-> (out_data.target_index == '0 && !out_data.updated && out_data.read_value == UNKNOWN_CELL), "out-of-bounds beat carries data")
  `OGAM_ASSERT(a_load_after_seq, out_load |-> ($past(state) == S_WB || $past(state) == S_CHK || $past(state) == S_OUT), "result loaded without a finished item")

endmodule

`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for occupancy_grid_affine_merge: directed and random beats
// are checked by a scoreboard class that keeps its own copy of the merged grid.
// Depends on ogam_pkg and the block's RTL only.
`timescale 1ns / 1ps

module testbench;
  import ogam_pkg::*;

  localparam int GRID_SIDE       = 512;
  localparam int GRID_CELLS      = GRID_SIDE * GRID_SIDE;
  localparam int FRAC            = 16;
  localparam int WATCHDOG_LIMIT  = 3 * GRID_CELLS;
  localparam int DRAIN_CYCLES    = 20;
  localparam int RANDOM_PHASES   = 9;
  localparam int ITEMS_PER_PHASE = 100;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  class grid_merge_scoreboard;
    logic signed [CELL_W-1:0] cells [GRID_CELLS];
    logic signed [COEF_W-1:0] xc, xr, xo, yc, yr, yo;
    logic [SIZE_W-1:0] width_reg, height_reg;
    out_item_t expected_cells [$];
    int unsigned recent_targets [$];
    int mismatches, checked, merges, merges_in, stores, reads, clears;

    function new();
      foreach (cells[i]) cells[i] = UNKNOWN_CELL;
      xc = 32'sd65536; xr = 0; xo = 0;
      yc = 0; yr = 32'sd65536; yo = 0;
      width_reg = 10'd512;
      height_reg = 10'd512;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_X_FROM_COL:    xc = value;
        CFG_X_FROM_ROW:    xr = value;
        CFG_X_OFFSET:      xo = value;
        CFG_Y_FROM_COL:    yc = value;
        CFG_Y_FROM_ROW:    yr = value;
        CFG_Y_OFFSET:      yo = value;
        CFG_MERGED_WIDTH:  width_reg = value[SIZE_W-1:0];
        CFG_MERGED_HEIGHT: height_reg = value[SIZE_W-1:0];
        default: ;
      endcase
    endfunction

    // Affine term in Q.FRAC, rounded half away from zero.
    function longint round_axis(logic signed [COEF_W-1:0] a_col,
                                logic signed [COEF_W-1:0] a_row,
                                logic signed [COEF_W-1:0] off, longint col, longint row);
      longint acc;
      longint half;
      half = longint'(1) << (FRAC - 1);
      acc = longint'(a_col) * col + longint'(a_row) * row + longint'(off);
      if (acc >= 0) return (acc + half) >>> FRAC;
      return -((-acc + half) >>> FRAC);
    endfunction

    function out_item_t merge_cell(in_item_t it);
      out_item_t r;
      longint mx, my, col, row;
      int w, h, idx;
      r = '0;
      r.read_value = UNKNOWN_CELL;
      w = (int'(width_reg) > GRID_SIDE) ? GRID_SIDE : int'(width_reg);
      h = (int'(height_reg) > GRID_SIDE) ? GRID_SIDE : int'(height_reg);
      col = longint'(it.src_col);
      row = longint'(it.src_row);
      case (it.op)
        OP_MERGE: begin
          merges++;
          mx = round_axis(xc, xr, xo, col, row);
          my = round_axis(yc, yr, yo, col, row);
          if (mx >= 0 && mx < longint'(w) && my >= 0 && my < longint'(h)) begin
            idx = int'(my) * w + int'(mx);
            merges_in++;
            r.in_bounds = 1'b1;
            r.target_index = GIDX_W'(idx);
            // higher value wins; unknown never lands
            if (it.cell_value >= 0 && cells[idx] < it.cell_value) begin
              cells[idx] = it.cell_value;
              r.updated = 1'b1;
              stores++;
            end
            r.read_value = cells[idx];
            recent_targets.insert(recent_targets.size(), idx);
            if (recent_targets.size() > 64) void'(recent_targets.pop_front());
          end
        end
        OP_READ, OP_CLEAR: begin
          if (it.op == OP_READ) reads++;
          else clears++;
          if (int'(it.grid_index) < w * h) begin
            r.in_bounds = 1'b1;
            r.target_index = it.grid_index;
            if (it.op == OP_CLEAR) begin
              cells[it.grid_index] = UNKNOWN_CELL;
              r.updated = 1'b1;
            end
            r.read_value = cells[it.grid_index];
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_item(in_item_t it);
      expected_cells.insert(expected_cells.size(), merge_cell(it));
    endfunction

    function void check_beat(out_item_t got);
      out_item_t want;
      if (expected_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected beat: inb %0d tgt %0d upd %0d val %0d",
                   $time, got.in_bounds, got.target_index, got.updated, got.read_value);
        return;
      end
      want = expected_cells.pop_front();
      checked++;
      if (got.in_bounds !== want.in_bounds || got.target_index !== want.target_index ||
          got.updated !== want.updated || got.read_value !== want.read_value) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: exp/got inb %0d/%0d tgt %0d/%0d upd %0d/%0d val %0d/%0d",
                   $time, want.in_bounds, got.in_bounds, want.target_index,
                   got.target_index, want.updated, got.updated, want.read_value,
                   got.read_value);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  grid_merge_scoreboard sb;
  int  idle_cycles = 0;
  int  settings = 0;
  int  sent = 0;
  int  cur_w = GRID_SIDE;
  int  cur_h = GRID_SIDE;
  bit  calm = 1'b0;

  occupancy_grid_affine_merge dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predict on every accepted input beat, check every accepted result beat.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_item(in_data);
      if (out_valid && !out_stall) sb.check_beat(out_data);
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 13);
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("testbench: done, errors");
    $finish;
  end

  function automatic in_item_t pack_item(logic [1:0] op, logic [SRC_W-1:0] col,
                                         logic [SRC_W-1:0] row, logic signed [CELL_W-1:0] val,
                                         logic [GIDX_W-1:0] gidx);
    in_item_t it;
    it.op = op;
    it.src_col = col;
    it.src_row = row;
    it.cell_value = val;
    it.grid_index = gidx;
    return it;
  endfunction

  // Present one beat and hold it until accepted; valid stays high afterwards.
  task automatic send_item(input in_item_t it);
    if (!calm && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Drain all pending results, then write every register.
  task automatic apply_settings(input logic [CFG_DATA_W-1:0] xc, xr, xo, yc, yr, yo,
                                input logic [SIZE_W-1:0] w, h);
    logic [CFG_DATA_W-1:0] vals [8];
    vals[CFG_X_FROM_COL] = xc;
    vals[CFG_X_FROM_ROW] = xr;
    vals[CFG_X_OFFSET] = xo;
    vals[CFG_Y_FROM_COL] = yc;
    vals[CFG_Y_FROM_ROW] = yr;
    vals[CFG_Y_OFFSET] = yo;
    vals[CFG_MERGED_WIDTH] = $urandom();
    vals[CFG_MERGED_WIDTH][SIZE_W-1:0] = w;
    vals[CFG_MERGED_HEIGHT] = $urandom();
    vals[CFG_MERGED_HEIGHT][SIZE_W-1:0] = h;
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_cells.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    for (int i = CFG_X_FROM_COL; i <= CFG_MERGED_HEIGHT; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data <= vals[i];
      sb.set_reg(cfg_idx_t'(i), vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings++;
    cur_w = (int'(w) > GRID_SIDE) ? GRID_SIDE : int'(w);
    cur_h = (int'(h) > GRID_SIDE) ? GRID_SIDE : int'(h);
  endtask

  initial begin
    int w, h, n, pick, base_col, base_row, cxc, cxr, cyc, cyr;
    bit noise;
    longint off_x, off_y;
    logic [SRC_W-1:0] col, row;
    logic signed [CELL_W-1:0] val;
    logic [GIDX_W-1:0] gidx;
    logic [1:0] op;

    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Identity map on the full grid: max priority, corners, unknown, reads and clears.
    apply_settings(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 10'd512, 10'd512);
    send_item(pack_item(OP_MERGE, 0, 0, 8'sd0, 0));
    send_item(pack_item(OP_MERGE, 0, 0, 8'sd100, 0));
    send_item(pack_item(OP_MERGE, 0, 0, 8'sd50, 0));
    send_item(pack_item(OP_MERGE, 0, 0, -8'sd1, 0));
    send_item(pack_item(OP_MERGE, 511, 511, 8'sd127, 0));
    send_item(pack_item(OP_MERGE, 512, 3, 8'sd10, 0));
    send_item(pack_item(OP_MERGE, 10'h3FF, 10'h3FF, -8'sd128, 18'h3FFFF));
    send_item(pack_item(OP_MERGE, 7, 9, -8'sd128, 0));
    send_item(pack_item(OP_MERGE, 7, 9, 8'sd0, 0));
    send_item(pack_item(OP_READ, 0, 0, 0, 0));
    send_item(pack_item(OP_READ, 0, 0, 0, 18'h3FFFF));
    send_item(pack_item(OP_CLEAR, 0, 0, 0, 18'h3FFFF));
    send_item(pack_item(OP_READ, 0, 0, 0, 18'h3FFFF));
    send_item(pack_item(OP_CLEAR, 0, 0, 0, 0));
    send_item(pack_item(OP_READ, 0, 0, 0, GIDX_W'(9 * GRID_SIDE + 7)));
    send_item(pack_item(OP_UNUSED, 10'h3FF, 10'h3FF, -8'sd1, 18'h3FFFF));

    // Half-cell steps exercise rounding away from zero; oversize dims saturate.
    apply_settings(32'h0000_8000, 0, 0, 0, 32'h0001_8000, 32'hFFFF_8000, 10'd1023, 10'd700);
    send_item(pack_item(OP_MERGE, 1, 1, 8'sd60, 0));
    send_item(pack_item(OP_MERGE, 3, 0, 8'sd5, 0));
    send_item(pack_item(OP_MERGE, 1, 2, 8'sd70, 0));
    send_item(pack_item(OP_READ, 0, 0, 0, GIDX_W'(GRID_SIDE + 1)));

    // Zero width: nothing lands.
    apply_settings(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 10'd0, 10'd5);
    send_item(pack_item(OP_MERGE, 0, 0, 8'sd1, 0));
    send_item(pack_item(OP_READ, 0, 0, 0, 0));

    // Extreme coefficients that nearly cancel along the diagonal.
    apply_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'h0010_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                   0, 10'd512, 10'd1);
    send_item(pack_item(OP_MERGE, 1023, 1023, 8'sd99, 0));
    send_item(pack_item(OP_MERGE, 0, 1023, 8'sd5, 0));
    send_item(pack_item(OP_MERGE, 512, 0, 8'sd7, 0));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin w = 512; h = 512; end
        1: begin w = 1023; h = 1023; end
        2: begin w = 1; h = 512; end
        3: begin w = 37; h = 0; end
        4: begin w = 512; h = 1; end
        5: begin w = 64; h = 64; end
        6: begin w = 300; h = 200; end
        default: begin w = $urandom_range(1, 1023); h = $urandom_range(1, 1023); end
      endcase
      noise = (p == RANDOM_PHASES - 1);
      n = (p == 3) ? 20 : ITEMS_PER_PHASE;
      base_col = $urandom_range(0, 960);
      base_row = $urandom_range(0, 960);
      cxc = $urandom_range(32768, 131072);
      if ($urandom_range(1)) cxc = -cxc;
      cyr = $urandom_range(32768, 131072);
      if ($urandom_range(1)) cyr = -cyr;
      cxr = int'($urandom_range(0, 32768)) - 16384;
      cyc = int'($urandom_range(0, 32768)) - 16384;
      // center the source window on the merged grid
      off_x = (longint'(((w > GRID_SIDE) ? GRID_SIDE : w) / 2) << FRAC)
              - longint'(cxc) * longint'(base_col + 32)
              - longint'(cxr) * longint'(base_row + 32);
      off_y = (longint'(((h > GRID_SIDE) ? GRID_SIDE : h) / 2) << FRAC)
              - longint'(cyc) * longint'(base_col + 32)
              - longint'(cyr) * longint'(base_row + 32);
      if (noise)
        apply_settings($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                       SIZE_W'(w), SIZE_W'(h));
      else
        apply_settings(cxc, cxr, off_x[31:0], cyc, cyr, off_y[31:0], SIZE_W'(w), SIZE_W'(h));

      for (int k = 0; k < n; k++) begin
        calm = (sent >= 350 && sent < 500);
        pick = $urandom_range(99);
        col = SRC_W'($urandom_range(0, 1023));
        row = SRC_W'($urandom_range(0, 1023));
        val = CELL_W'($urandom_range(0, 255));
        gidx = GIDX_W'($urandom_range(0, GRID_CELLS - 1));
        if (pick < 65) begin
          op = OP_MERGE;
          if ($urandom_range(99) < 80) begin
            col = SRC_W'(base_col + int'($urandom_range(0, 63)));
            row = SRC_W'(base_row + int'($urandom_range(0, 63)));
          end
          pick = $urandom_range(99);
          if (pick < 10) val = -8'sd1;
          else if (pick >= 15) val = CELL_W'($urandom_range(0, 100));
        end else if (pick < 92) begin
          op = (pick < 80) ? OP_READ : OP_CLEAR;
          pick = $urandom_range(99);
          if (pick < 60 && sb.recent_targets.size() != 0)
            gidx = GIDX_W'(sb.recent_targets[$urandom_range(0, sb.recent_targets.size() - 1)]);
          else if (pick < 85 && cur_w * cur_h > 0)
            gidx = GIDX_W'($urandom_range(0, cur_w * cur_h - 1));
        end else begin
          op = OP_UNUSED;
        end
        send_item(pack_item(op, col, row, val, gidx));
      end
    end

    calm = 1'b0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_cells.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("testbench: %0d beats, %0d register sets, %0d merges (%0d on grid, %0d kept)",
             sent, settings, sb.merges, sb.merges_in, sb.stores);
    $display("testbench: %0d reads, %0d clears, %0d results checked, %0d mismatches",
             sb.reads, sb.clears, sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/ogam_pkg.sv
rtl/core/ogam_ram.sv
rtl/core/occupancy_grid_affine_merge.sv
sim/testbench.sv
